/* src/sosd_pkg.sv */
package sosd_pkg;

    // Palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int RGB_W         = 24;

    // Write request into the palette memory
    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        logic [RGB_W-1:0]  rgb;
    } t_pal_wr;

endpackage

/* src/sosd_palette_ram.sv */
module sosd_palette_ram
    import sosd_pkg::*;
(
    input  logic              i_clk,
    input  t_pal_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [PAL_AW-1:0] i_rd_addr,
    output logic [RGB_W-1:0]  o_rd_data
);

    logic [RGB_W-1:0] r_mem [PALETTE_DEPTH];
    logic [RGB_W-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.rgb;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/sprite_opcode_stream_decoder_top.sv */
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: action; tdata: stream byte,
//                                                    palette slot, red, green, blue
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser: kind; tdata: x, y, index,
//                                                    red, green, blue, outside flag
// cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One input beat per cycle while s_axis_tready is high; a result goes from its byte through
// the read stage (synchronous palette read) and then the output register to m_axis.
// Reset (i_rst_n low, synchronous) restarts the sprite with x = 0 and y = -1;
// palette contents are undefined until written.
// s_axis_tready drops only when both the read stage and the output register are full
// and m_axis is stalled.
module sprite_opcode_stream_decoder_top
    import sosd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [7:0] stream_byte, [15:8] palette_slot,
                                       // [23:16] red_in, [31:24] green_in, [39:32] blue_in
    input  logic [0:0]  s_axis_tuser,  // [0] action
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // [15:0] pixel_x, [31:16] pixel_y, [39:32] color_index,
                                       // [47:40] red_out, [55:48] green_out,
                                       // [63:56] blue_out, [64] outside_image, rest zero
    output logic [1:0]  m_axis_tuser,  // [1:0] kind
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [1:0] PH_COUNT = 2'd0;
    localparam logic [1:0] PH_OPER  = 2'd1;
    localparam logic [1:0] PH_DRAW  = 2'd2;
    localparam logic [1:0] PH_PAD   = 2'd3;

    localparam logic [1:0] KIND_PIXEL    = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_BADOP    = 2'd2;
    localparam logic [1:0] KIND_BADCOLOR = 2'd3;

    localparam logic [7:0] OP_NOP  = 8'd0;
    localparam logic [7:0] OP_ROW  = 8'd1;
    localparam logic [7:0] OP_END  = 8'd2;
    localparam logic [7:0] OP_SKIP = 8'd3;
    localparam logic [7:0] OP_DRAW = 8'd4;

    localparam logic [1:0] REG_PAL_ENTRIES = 2'd0;
    localparam logic [1:0] REG_WIDTH       = 2'd1;
    localparam logic [1:0] REG_HEIGHT      = 2'd2;

    localparam logic [8:0]  DEPTH_9    = 9'(PALETTE_DEPTH);
    localparam logic [15:0] Y_RESTART  = 16'hFFFF;

    // Configuration registers
    logic [8:0]  r_pal_entries;
    logic [15:0] r_width;
    logic [15:0] r_height;

    // Sprite state
    logic [1:0]  r_phase,     n_phase;
    logic [7:0]  r_count,     n_count;
    logic [7:0]  r_left,      n_left;
    logic        r_pad_pending, n_pad_pending;
    logic [15:0] r_x,         n_x;
    logic [15:0] r_y,         n_y;

    // Read stage (palette data arrives here)
    logic        r_s1_valid,  n_s1_valid;
    logic [1:0]  r_s1_kind,   n_s1_kind;
    logic [15:0] r_s1_x,      n_s1_x;
    logic [15:0] r_s1_y,      n_s1_y;
    logic [7:0]  r_s1_index,  n_s1_index;
    logic        r_s1_outside, n_s1_outside;

    // Output register
    logic        r_o_valid;
    logic [1:0]  r_o_kind;
    logic [15:0] r_o_x;
    logic [15:0] r_o_y;
    logic [7:0]  r_o_index;
    logic [RGB_W-1:0] r_o_rgb;
    logic        r_o_outside;

    logic        s1_adv;
    logic        in_accept;
    logic        is_byte;
    logic [7:0]  in_byte;
    logic [7:0]  in_slot;
    logic [8:0]  limit;
    logic        rd_en;
    logic [RGB_W-1:0] rd_data;
    t_pal_wr     pal_wr;

    assign s1_adv        = r_s1_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_byte       = !s_axis_tuser[0];
    assign in_byte       = s_axis_tdata[7:0];
    assign in_slot       = s_axis_tdata[15:8];
    assign limit         = (r_pal_entries < DEPTH_9) ? r_pal_entries : DEPTH_9;
    assign o_cfg_ready   = 1'b1;

    // Palette write and draw-byte read
    assign pal_wr.en   = in_accept && !is_byte && ({1'b0, in_slot} < DEPTH_9);
    assign pal_wr.addr = in_slot[PAL_AW-1:0];
    assign pal_wr.rgb  = {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};
    assign rd_en       = in_accept && is_byte && (r_phase == PH_DRAW);

    sosd_palette_ram u_palette (
        .i_clk     (i_clk),
        .i_wr      (pal_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (in_byte[PAL_AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Decode one stream byte
    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_left        = r_left;
        n_pad_pending = r_pad_pending;
        n_x           = r_x;
        n_y           = r_y;
        n_s1_valid    = 1'b0;
        n_s1_kind     = KIND_PIXEL;
        n_s1_x        = r_x;
        n_s1_y        = r_y;
        n_s1_index    = in_byte;
        n_s1_outside  = r_x[15] || r_y[15] || (r_x >= r_width) || (r_y >= r_height);
        if (is_byte) begin
            case (r_phase)
                PH_COUNT: begin
                    n_count = in_byte;
                    n_phase = PH_OPER;
                end
                PH_OPER: begin
                    case (in_byte)
                        OP_NOP: n_phase = PH_COUNT;
                        OP_ROW: begin
                            n_y     = r_y + 16'd1;
                            n_x     = '0;
                            n_phase = PH_COUNT;
                        end
                        OP_END: begin
                            n_s1_valid = 1'b1;
                            n_s1_kind  = KIND_END;
                        end
                        OP_SKIP: begin
                            n_x     = r_x + {8'd0, r_count};
                            n_phase = PH_COUNT;
                        end
                        OP_DRAW: begin
                            n_left        = r_count;
                            n_pad_pending = r_count[0];
                            n_phase       = (r_count != 8'd0) ? PH_DRAW : PH_COUNT;
                        end
                        default: begin
                            n_s1_valid = 1'b1;
                            n_s1_kind  = KIND_BADOP;
                        end
                    endcase
                end
                PH_DRAW: begin
                    n_s1_valid = 1'b1;
                    if ({1'b0, in_byte} >= limit) begin
                        n_s1_kind = KIND_BADCOLOR;
                    end else begin
                        n_x    = r_x + 16'd1;
                        n_left = r_left - 8'd1;
                        if (r_left == 8'd1) begin
                            n_phase = r_pad_pending ? PH_PAD : PH_COUNT;
                        end
                    end
                end
                default: begin
                    n_pad_pending = 1'b0;
                    n_phase       = PH_COUNT;
                end
            endcase
            // Restart the sprite after an end or an error
            if (n_s1_valid && (n_s1_kind != KIND_PIXEL)) begin
                n_phase       = PH_COUNT;
                n_count       = '0;
                n_left        = '0;
                n_pad_pending = 1'b0;
                n_x           = '0;
                n_y           = Y_RESTART;
                n_s1_x        = '0;
                n_s1_y        = '0;
                n_s1_outside  = 1'b0;
                if (n_s1_kind != KIND_BADCOLOR) begin
                    n_s1_index = '0;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_entries <= DEPTH_9;
            r_width       <= '0;
            r_height      <= '0;
            r_phase       <= PH_COUNT;
            r_count       <= '0;
            r_left        <= '0;
            r_pad_pending <= 1'b0;
            r_x           <= '0;
            r_y           <= Y_RESTART;
            r_s1_valid    <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_PAL_ENTRIES: r_pal_entries <= i_cfg_data[8:0];
                    REG_WIDTH:       r_width       <= i_cfg_data;
                    REG_HEIGHT:      r_height      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_accept && is_byte) begin
                r_phase       <= n_phase;
                r_count       <= n_count;
                r_left        <= n_left;
                r_pad_pending <= n_pad_pending;
                r_x           <= n_x;
                r_y           <= n_y;
            end
            // Advance the read stage
            if (in_accept) begin
                r_s1_valid <= is_byte && n_s1_valid;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            // Advance the output register
            if (!r_o_valid || m_axis_tready) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    // Payload of the read stage and the output register
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind    <= n_s1_kind;
            r_s1_x       <= n_s1_x;
            r_s1_y       <= n_s1_y;
            r_s1_index   <= n_s1_index;
            r_s1_outside <= n_s1_outside;
        end
        if (s1_adv) begin
            r_o_kind    <= r_s1_kind;
            r_o_x       <= r_s1_x;
            r_o_y       <= r_s1_y;
            r_o_index   <= r_s1_index;
            r_o_rgb     <= (r_s1_kind == KIND_PIXEL) ? rd_data : '0;
            r_o_outside <= r_s1_outside;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tdata  = {15'd0, r_o_outside, r_o_rgb[7:0], r_o_rgb[15:8], r_o_rgb[23:16],
                            r_o_index, r_o_y, r_o_x};

    // Checks
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are stalled");

    a_report_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_kind != KIND_PIXEL)) |->
            (r_o_rgb == '0 && !r_o_outside && r_o_x == '0 && r_o_y == '0))
        else $error("end or error beat carries pixel payload");

    a_pad_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAD) |-> r_pad_pending)
        else $error("pad phase without a pending pad byte");

    a_reset_restarts: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == PH_COUNT && r_y == Y_RESTART && !r_s1_valid && !r_o_valid))
        else $error("reset did not restart the sprite");

endmodule
